// ===== hw/rtl/ranging_report_deframer_macros.svh =====
// Assertion macros for the ranging report deframer checker.
// Expects i_clk and i_rst_n to be visible where the macros are used.
`ifndef RANGING_REPORT_DEFRAMER_MACROS_SVH
`define RANGING_REPORT_DEFRAMER_MACROS_SVH

// Checked only while the block is out of reset.
`define RRD_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("ranging report deframer check failed");

// Checked on every edge, reset included.
`define RRD_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge i_clk) prop) \
        else $error("ranging report deframer check failed at reset");

`endif

// ===== hw/rtl/rrd_pkg.sv =====
// Shared types, constants and code-mapping functions of the ranging report deframer.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package rrd_pkg;

    localparam int FRAME_LEN_DEF = 24;
    localparam int QUEUE_DEPTH_DEF = 2;

    // Window positions of the decoded fields; byte 0 is the first header byte.
    localparam int FIELD_LO = 2;
    localparam int FIELD_HI = 21;

    localparam logic [7:0] HDR_BYTE  = 8'hFA;
    localparam logic [7:0] TAIL_BYTE = 8'hBB;

    localparam int CARRIER_W = 17;
    localparam int BITRATE_W = 14;
    localparam int PULSE_W   = 8;

    localparam logic signed [CARRIER_W-1:0] CARRIER_CH1     = 17'sd34944;
    localparam logic signed [CARRIER_W-1:0] CARRIER_CH2     = 17'sd39936;
    localparam logic signed [CARRIER_W-1:0] CARRIER_CH3     = 17'sd44928;
    localparam logic signed [CARRIER_W-1:0] CARRIER_CH5     = 17'sd64896;
    localparam logic signed [CARRIER_W-1:0] CARRIER_INVALID = -17'sd1;

    localparam logic signed [BITRATE_W-1:0] BITRATE_110     = 14'sd110;
    localparam logic signed [BITRATE_W-1:0] BITRATE_850     = 14'sd850;
    localparam logic signed [BITRATE_W-1:0] BITRATE_6800    = 14'sd6800;
    localparam logic signed [BITRATE_W-1:0] BITRATE_INVALID = -14'sd1;

    localparam logic signed [PULSE_W-1:0] PULSE_16      = 8'sd16;
    localparam logic signed [PULSE_W-1:0] PULSE_64      = 8'sd64;
    localparam logic signed [PULSE_W-1:0] PULSE_INVALID = -8'sd1;

    // Codes as they appear on the link.
    localparam logic [7:0] CH_CODE_1 = 8'd1;
    localparam logic [7:0] CH_CODE_2 = 8'd2;
    localparam logic [7:0] CH_CODE_3 = 8'd3;
    localparam logic [7:0] CH_CODE_4 = 8'd4;
    localparam logic [7:0] CH_CODE_5 = 8'd5;
    localparam logic [7:0] CH_CODE_7 = 8'd7;
    localparam logic [7:0] RATE_CODE_110K  = 8'd0;
    localparam logic [7:0] RATE_CODE_850K  = 8'd1;
    localparam logic [7:0] RATE_CODE_6M8   = 8'd2;
    localparam logic [7:0] PRF_CODE_16M    = 8'd1;
    localparam logic [7:0] PRF_CODE_64M    = 8'd2;

    typedef enum logic [2:0] {
        PH_HUNT    = 3'b001,
        PH_HDR     = 3'b010,
        PH_COLLECT = 3'b100
    } t_phase;

    // Raw fields of an accepted frame, as they travel through the queue.
    typedef struct packed {
        logic [15:0] origin_id;
        logic [7:0]  origin_kind;
        logic [15:0] dest_id;
        logic [7:0]  dest_kind;
        logic [31:0] distance;
        logic [31:0] stamp;
        logic [7:0]  sequence_res;
        logic [15:0] rx_power;
        logic [7:0]  chan_code;
        logic [7:0]  rate_code;
        logic [7:0]  prf_code;
    } t_frame;

    function automatic logic signed [CARRIER_W-1:0] map_carrier(input logic [7:0] code);
        logic signed [CARRIER_W-1:0] val;
        case (code)
            CH_CODE_1:            val = CARRIER_CH1;
            CH_CODE_2, CH_CODE_4: val = CARRIER_CH2;
            CH_CODE_3:            val = CARRIER_CH3;
            CH_CODE_5, CH_CODE_7: val = CARRIER_CH5;
            default:              val = CARRIER_INVALID;
        endcase
        return val;
    endfunction

    function automatic logic signed [BITRATE_W-1:0] map_bitrate(input logic [7:0] code);
        logic signed [BITRATE_W-1:0] val;
        case (code)
            RATE_CODE_110K: val = BITRATE_110;
            RATE_CODE_850K: val = BITRATE_850;
            RATE_CODE_6M8:  val = BITRATE_6800;
            default:        val = BITRATE_INVALID;
        endcase
        return val;
    endfunction

    function automatic logic signed [PULSE_W-1:0] map_pulse(input logic [7:0] code);
        logic signed [PULSE_W-1:0] val;
        case (code)
            PRF_CODE_16M: val = PULSE_16;
            PRF_CODE_64M: val = PULSE_64;
            default:      val = PULSE_INVALID;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ranging_report_deframer.sv =====
// Ranging report deframer: one received byte per input beat, one decoded report per
// good frame. A byte is taken every cycle while the two-frame queue between the byte
// front end and the output register has room; a frame whose tail is not 0xBB 0xBB is
// dropped without a result. A good frame's report passes from the queue into the output
// register once the output side is free. There is no clearing pass after reset: only
// bytes of the current window are ever read. Depends on rrd_pkg and the rrd_ modules.
`default_nettype none

module ranging_report_deframer import rrd_pkg::*; #(
    parameter int FRAME_LEN   = FRAME_LEN_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [7:0]                  i_rx_byte,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic        [15:0]          o_origin_id,
    output logic signed [7:0]           o_origin_kind,
    output logic        [15:0]          o_dest_id,
    output logic signed [7:0]           o_dest_kind,
    output logic signed [31:0]          o_distance,
    output logic signed [31:0]          o_stamp,
    output logic        [7:0]           o_sequence_res,
    output logic signed [15:0]          o_rx_power,
    output logic signed [CARRIER_W-1:0] o_carrier_tenth_mhz,
    output logic signed [BITRATE_W-1:0] o_bitrate_kbps,
    output logic signed [PULSE_W-1:0]   o_pulse_rate_mhz
);

    logic   push;
    logic   pop;
    logic   full;
    logic   empty;
    t_frame front_frame;
    t_frame queue_frame;

    rrd_front #(
        .FRAME_LEN (FRAME_LEN)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_rx_byte (i_rx_byte),
        .i_full    (full),
        .o_push    (push),
        .o_frame   (front_frame)
    );

    rrd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_frame (front_frame),
        .i_pop   (pop),
        .o_frame (queue_frame),
        .o_full  (full),
        .o_empty (empty)
    );

    rrd_back u_back (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_empty             (empty),
        .i_frame             (queue_frame),
        .o_pop               (pop),
        .o_valid             (o_valid),
        .i_ready             (i_ready),
        .o_origin_id         (o_origin_id),
        .o_origin_kind       (o_origin_kind),
        .o_dest_id           (o_dest_id),
        .o_dest_kind         (o_dest_kind),
        .o_distance          (o_distance),
        .o_stamp             (o_stamp),
        .o_sequence_res      (o_sequence_res),
        .o_rx_power          (o_rx_power),
        .o_carrier_tenth_mhz (o_carrier_tenth_mhz),
        .o_bitrate_kbps      (o_bitrate_kbps),
        .o_pulse_rate_mhz    (o_pulse_rate_mhz)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/rrd_queue.sv =====
// Short first-in first-out queue of accepted frames between front and back.
// Depends on rrd_pkg for the frame record type.
`default_nettype none

module rrd_queue import rrd_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_frame i_frame,
    input  logic   i_pop,
    output t_frame o_frame,
    output logic   o_full,
    output logic   o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    t_frame           r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             push_ok;
    logic             pop_ok;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;
    assign o_frame = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (push_ok) begin
            n_wr = (r_wr == LAST_PTR) ? '0 : r_wr + 1'b1;
        end
        if (pop_ok) begin
            n_rd = (r_rd == LAST_PTR) ? '0 : r_rd + 1'b1;
        end
        if (push_ok && !pop_ok) begin
            n_cnt = r_cnt + 1'b1;
        end else if (pop_ok && !push_ok) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr] <= i_frame;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/rrd_front.sv =====
// Front end: takes received bytes, hunts for the header, counts the window,
// captures the field bytes and checks the tail. Depends on rrd_pkg.
`default_nettype none

module rrd_front import rrd_pkg::*; #(
    parameter int FRAME_LEN = FRAME_LEN_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_rx_byte,
    input  logic       i_full,
    output logic       o_push,
    output t_frame     o_frame
);

    localparam int CNT_W = $clog2(FRAME_LEN + 1);
    localparam logic [CNT_W-1:0] LAST_IDX   = CNT_W'(FRAME_LEN - 1);
    localparam logic [CNT_W-1:0] PENULT_IDX = CNT_W'(FRAME_LEN - 2);
    localparam logic [CNT_W-1:0] FIRST_IDX  = CNT_W'(FIELD_LO);

    t_phase           r_phase, n_phase;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_tail, n_tail;
    logic [7:0]       r_fb [FIELD_LO:FIELD_HI];
    logic             accept;

    assign o_ready = !i_full;
    assign accept  = i_valid && !i_full;

    always_comb begin
        n_phase = r_phase;
        n_count = r_count;
        n_tail  = r_tail;
        o_push  = 1'b0;
        if (accept) begin
            case (r_phase)
                PH_COLLECT: begin
                    n_count = r_count + 1'b1;
                    if (r_count == PENULT_IDX) begin
                        n_tail = (i_rx_byte == TAIL_BYTE);
                    end
                    // The last window byte always closes the window, good or not.
                    if (r_count == LAST_IDX) begin
                        n_phase = PH_HUNT;
                        n_count = '0;
                        o_push  = r_tail && (i_rx_byte == TAIL_BYTE);
                    end
                end
                PH_HDR: begin
                    if (i_rx_byte == HDR_BYTE) begin
                        n_phase = PH_COLLECT;
                        n_count = FIRST_IDX;
                    end else begin
                        n_phase = PH_HUNT;
                    end
                end
                default: begin
                    n_count = '0;
                    n_phase = (i_rx_byte == HDR_BYTE) ? PH_HDR : PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_count <= '0;
            r_tail  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_tail  <= n_tail;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = FIELD_LO; k <= FIELD_HI; k++) begin
            if (accept && r_phase == PH_COLLECT && r_count == CNT_W'(k)) begin
                r_fb[k] <= i_rx_byte;
            end
        end
    end

    // All field bytes sit well before the tail, so they are settled when the frame is pushed.
    always_comb begin
        o_frame.origin_id    = {r_fb[3], r_fb[2]};
        o_frame.origin_kind  = r_fb[4];
        o_frame.dest_id      = {r_fb[6], r_fb[5]};
        o_frame.dest_kind    = r_fb[7];
        o_frame.distance     = {r_fb[11], r_fb[10], r_fb[9], r_fb[8]};
        o_frame.stamp        = {r_fb[15], r_fb[14], r_fb[13], r_fb[12]};
        o_frame.sequence_res = r_fb[16];
        o_frame.rx_power     = {r_fb[18], r_fb[17]};
        o_frame.chan_code    = r_fb[19];
        o_frame.rate_code    = r_fb[20];
        o_frame.prf_code     = r_fb[21];
    end

endmodule

`default_nettype wire

// ===== hw/rtl/rrd_back.sv =====
// Back end: takes frames from the queue, maps the channel, rate and prf codes
// and holds the result in the output register. Depends on rrd_pkg.
`default_nettype none

module rrd_back import rrd_pkg::*; (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_empty,
    input  t_frame                      i_frame,
    output logic                        o_pop,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic        [15:0]          o_origin_id,
    output logic signed [7:0]           o_origin_kind,
    output logic        [15:0]          o_dest_id,
    output logic signed [7:0]           o_dest_kind,
    output logic signed [31:0]          o_distance,
    output logic signed [31:0]          o_stamp,
    output logic        [7:0]           o_sequence_res,
    output logic signed [15:0]          o_rx_power,
    output logic signed [CARRIER_W-1:0] o_carrier_tenth_mhz,
    output logic signed [BITRATE_W-1:0] o_bitrate_kbps,
    output logic signed [PULSE_W-1:0]   o_pulse_rate_mhz
);

    logic r_valid;

    // The output register reloads in the same cycle its beat is taken.
    assign o_pop   = !i_empty && (!r_valid || i_ready);
    assign o_valid = r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            o_origin_id         <= i_frame.origin_id;
            o_origin_kind       <= signed'(i_frame.origin_kind);
            o_dest_id           <= i_frame.dest_id;
            o_dest_kind         <= signed'(i_frame.dest_kind);
            o_distance          <= signed'(i_frame.distance);
            o_stamp             <= signed'(i_frame.stamp);
            o_sequence_res      <= i_frame.sequence_res;
            o_rx_power          <= signed'(i_frame.rx_power);
            o_carrier_tenth_mhz <= map_carrier(i_frame.chan_code);
            o_bitrate_kbps      <= map_bitrate(i_frame.rate_code);
            o_pulse_rate_mhz    <= map_pulse(i_frame.prf_code);
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/rrd_checker.sv =====
// Port-level checks of the ranging report deframer, bound to the top level.
// Depends on rrd_pkg and the assertion macros header.
`default_nettype none
`include "ranging_report_deframer_macros.svh"

module rrd_checker import rrd_pkg::*; (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        o_valid,
    input  logic                        i_ready,
    input  logic signed [CARRIER_W-1:0] o_carrier_tenth_mhz,
    input  logic signed [BITRATE_W-1:0] o_bitrate_kbps,
    input  logic signed [PULSE_W-1:0]   o_pulse_rate_mhz
);

    logic carrier_ok;
    logic rate_ok;
    logic prf_ok;

    assign carrier_ok = (o_carrier_tenth_mhz == CARRIER_CH1) ||
                        (o_carrier_tenth_mhz == CARRIER_CH2) ||
                        (o_carrier_tenth_mhz == CARRIER_CH3) ||
                        (o_carrier_tenth_mhz == CARRIER_CH5) ||
                        (o_carrier_tenth_mhz == CARRIER_INVALID);
    assign rate_ok    = (o_bitrate_kbps == BITRATE_110) ||
                        (o_bitrate_kbps == BITRATE_850) ||
                        (o_bitrate_kbps == BITRATE_6800) ||
                        (o_bitrate_kbps == BITRATE_INVALID);
    assign prf_ok     = (o_pulse_rate_mhz == PULSE_16) ||
                        (o_pulse_rate_mhz == PULSE_64) ||
                        (o_pulse_rate_mhz == PULSE_INVALID);

    // A beat on offer is not withdrawn before it is taken.
    `RRD_ASSERT(a_out_hold, o_valid && !i_ready |=> o_valid)

    // Reset leaves no report on offer.
    `RRD_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> !o_valid)

    `RRD_ASSERT(a_carrier_legal, o_valid |-> carrier_ok)

    `RRD_ASSERT(a_rate_legal, o_valid |-> rate_ok)

    `RRD_ASSERT(a_prf_legal, o_valid |-> prf_ok)

endmodule

bind ranging_report_deframer rrd_checker u_rrd_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .o_valid             (o_valid),
    .i_ready             (i_ready),
    .o_carrier_tenth_mhz (o_carrier_tenth_mhz),
    .o_bitrate_kbps      (o_bitrate_kbps),
    .o_pulse_rate_mhz    (o_pulse_rate_mhz)
);

`default_nettype wire
